// File: rtl/core/wlas_pkg.sv
`default_nettype none
package wlas_pkg;

    localparam int NumChannels = 16;
    localparam int RamDepth    = 4096;
    localparam int RamAw       = 12;
    localparam int OutScale    = 786;
    localparam int GainMax     = 256;

    localparam logic [3:0] RegPage  = 4'hE;
    localparam logic [2:0] OffFreqLo  = 3'd0;
    localparam logic [2:0] OffFreqMid = 3'd1;
    localparam logic [2:0] OffFreqHi  = 3'd2;
    localparam logic [2:0] OffSel     = 3'd5;
    localparam logic [2:0] OffAmp     = 3'd6;
    localparam logic [2:0] OffCtl     = 3'd7;

    localparam logic [1:0] CfgInitialGain = 2'd0;
    localparam logic [1:0] CfgAutorange   = 2'd1;
    localparam logic [1:0] CfgRate48k     = 2'd2;
    localparam logic [1:0] CfgPinSums     = 2'd3;

    localparam logic OpWrite = 1'b0;
    localparam logic OpTick  = 1'b1;

    typedef struct packed {
        logic              clr;
        logic [RamAw-1:0]  clr_addr;
        logic              start;
        logic              run;
        logic [3:0]        chan;
        logic [2:0]        step;
        logic              p0;
        logic              p1;
        logic              p2;
        logic              commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [12:0] antilog(input logic [6:0] n);
        logic [12:0] m;
        m = 13'(({8'd0, n[3:0], 1'b0} + 13'd33) << n[6:4]);
        return 13'(m - 13'd33);
    endfunction

    function automatic logic [2:0] pan_weight(input logic [3:0] p);
        logic [2:0] w;
        unique case (p)
            4'd8, 4'd9, 4'd10: w = 3'd6;
            4'd11: w = 3'd5;
            4'd12: w = 3'd4;
            4'd13: w = 3'd3;
            4'd14: w = 3'd2;
            4'd15: w = 3'd1;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/wavetable_log_amp_synth_16ch.sv
`default_nettype none
// Sixteen-channel wavetable synthesiser with log-domain amplitude. After reset the
// 4096-byte wave and channel RAM is cleared; no item is taken during the clear. A write
// item is written to the RAM as it is taken. A tick item makes eight RAM read slots
// for each of the 16 channels through the single RAM read port, then the gain scaling,
// dither and saturation steps. The result waits in an output register; the next item is
// taken once the tick has been handed to that register.
module wavetable_log_amp_synth_16ch (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // operation, address[11:0], write_data[7:0], pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [8:0]  cfg_wdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // left_out, right_out, clipped, mix_left, mix_right,
                                       // gain_now, pad
);

    wlas_pkg::cmd_t    cmd;
    wlas_pkg::status_t status;
    logic        ram_we;
    logic [11:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    wlas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tdata[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wlas_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_accept (s_tvalid && s_tready),
        .in_op     (s_tdata[0]),
        .in_addr   (s_tdata[12:1]),
        .in_wdata  (s_tdata[20:13]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    wlas_ram #(
        .Width (8),
        .Depth (wlas_pkg::RamDepth)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// File: rtl/core/wlas_ram.sv
`default_nettype none
module wlas_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/wlas_ctrl.sv
`default_nettype none
module wlas_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              in_op,
    output logic                   s_tready,
    input  wire wlas_pkg::status_t status,
    output wlas_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHAN  = 3'd2;
    localparam logic [2:0] ST_P0    = 3'd3;
    localparam logic [2:0] ST_P1    = 3'd4;
    localparam logic [2:0] ST_P2    = 3'd5;
    localparam logic [2:0] ST_P3    = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [11:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.clr_addr = cnt_reg;
        cmd.chan   = cnt_reg[6:3];
        cmd.step   = cnt_reg[2:0];
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr  = 1'b1;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == 12'(wlas_pkg::RamDepth - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid && in_op == wlas_pkg::OpTick) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN: begin
                cmd.run  = 1'b1;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[6:0] == 7'(wlas_pkg::NumChannels * 8 - 1)) begin
                    state_next = ST_P0;
                end
            end
            ST_P0: begin
                cmd.p0     = 1'b1;
                state_next = ST_P1;
            end
            ST_P1: begin
                cmd.p1     = 1'b1;
                state_next = ST_P2;
            end
            ST_P2: begin
                cmd.p2     = 1'b1;
                state_next = ST_P3;
            end
            ST_P3: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/wlas_dp.sv
`default_nettype none
module wlas_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wlas_pkg::cmd_t    cmd,
    output wlas_pkg::status_t      status,
    input  wire logic              in_accept,
    input  wire logic              in_op,
    input  wire logic [11:0]       in_addr,
    input  wire logic [7:0]        in_wdata,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [8:0]        cfg_wdata,
    output logic                   ram_we,
    output logic [11:0]            ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic [11:0]            ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [87:0]            m_tdata
);

    logic        autorange_reg, rate_reg, pin_reg;
    logic [8:0]  gain_reg;
    logic        bank_reg;
    logic [23:0] phase_reg [16];
    logic [7:0]  amp_reg [16];
    logic [7:0]  flo_reg, fmid_reg, fhi_reg, ctl_reg;
    logic [3:0]  sel_reg;
    logic        carry_reg;
    logic signed [20:0] mixl_reg, mixr_reg;
    logic signed [30:0] prodl_reg, prodr_reg;
    logic signed [40:0] accl_reg, accr_reg;
    logic [15:0] resl_reg, resr_reg, resl_tmp_reg, resr_tmp_reg;
    logic signed [15:0] lo_reg, ro_reg;
    logic        clip_reg;
    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    logic [23:0] freq;
    logic [31:0] incw;
    logic [23:0] inc;
    logic [24:0] psum;
    logic [7:0]  smp, s8;
    logic        sgn, neg, contrib;
    logic [2:0]  pan;
    logic signed [13:0] lin;
    logic signed [17:0] addl, addr_r;
    logic signed [24:0] ol, orr;
    logic signed [16:0] pin;
    logic        clip_all;
    logic [8:0]  gain_new;

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign ram_we    = cmd.clr || (in_accept && in_op == wlas_pkg::OpWrite);
    assign ram_waddr = cmd.clr ? cmd.clr_addr : in_addr;
    assign ram_wdata = cmd.clr ? 8'd0 : in_wdata;

    always_comb begin
        unique case (cmd.step)
            3'd0: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffFreqLo, cmd.chan};
            3'd1: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffFreqMid, cmd.chan};
            3'd2: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffFreqHi, cmd.chan};
            3'd3: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffCtl, cmd.chan};
            3'd4: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffSel, cmd.chan};
            3'd5: ram_raddr = {wlas_pkg::RegPage, bank_reg, wlas_pkg::OffAmp, cmd.chan};
            3'd6: ram_raddr = {sel_reg, sel_reg[0], phase_reg[cmd.chan][23:17]};
            default: ram_raddr = '0;
        endcase
    end

    always_comb begin
        freq  = {fhi_reg, fmid_reg, flo_reg};
        incw  = 32'(freq) * (rate_reg ? 32'd125 : 32'd128);
        inc   = incw[30:7];
        psum  = {1'b0, inc} + {1'b0, phase_reg[cmd.chan]};
        smp   = ram_rdata;
        sgn   = smp[7];
        s8    = smp + amp_reg[cmd.chan];
        contrib = s8[7] != sgn;
        neg   = sgn ^ ctl_reg[4];
        pan   = wlas_pkg::pan_weight(ctl_reg[3:0]);
        lin   = $signed({1'b0, wlas_pkg::antilog(s8[6:0])});
        if (neg) begin
            lin = -lin;
        end
        addl   = contrib ? 18'(lin * $signed({1'b0, pan})) : '0;
        addr_r = contrib ? 18'(lin * $signed({1'b0, 3'd6 - pan})) : '0;
        ol  = 25'(accl_reg >>> 16);
        orr = 25'(accr_reg >>> 16);
        pin = 17'(lo_reg) + 17'(ro_reg);
        clip_all = clip_reg || (pin_reg && (pin > 17'sd32767 || pin < -17'sd32768));
        gain_new = (autorange_reg && clip_all && gain_reg > 9'd1) ? (gain_reg >> 1) : gain_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            autorange_reg <= 1'b1;
            rate_reg      <= 1'b0;
            pin_reg       <= 1'b1;
            gain_reg      <= 9'd3;
            bank_reg      <= 1'b0;
            resl_reg      <= '0;
            resr_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                phase_reg[i] <= '0;
                amp_reg[i]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    wlas_pkg::CfgInitialGain: begin
                        if (!cmd.commit) begin
                            gain_reg <= (cfg_wdata > 9'(wlas_pkg::GainMax)) ?
                                        9'(wlas_pkg::GainMax) : cfg_wdata;
                        end
                    end
                    wlas_pkg::CfgAutorange: autorange_reg <= cfg_wdata[0];
                    wlas_pkg::CfgRate48k:   rate_reg      <= cfg_wdata[0];
                    wlas_pkg::CfgPinSums:   pin_reg       <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.run && cmd.step == 3'd4) begin
                if (!flo_reg[0]) begin
                    phase_reg[cmd.chan] <= psum[23:0];
                end else begin
                    phase_reg[cmd.chan] <= inc;
                end
            end
            if (cmd.run && cmd.step == 3'd6 && carry_reg) begin
                amp_reg[cmd.chan] <= ram_rdata;
            end
            if (cmd.run && cmd.step == 3'd7) begin
                bank_reg <= ctl_reg[5] && (sgn || carry_reg);
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                gain_reg     <= gain_new;
                if (autorange_reg && clip_all) begin
                    resl_reg <= '0;
                    resr_reg <= '0;
                end else begin
                    resl_reg <= resl_tmp_reg;
                    resr_reg <= resr_tmp_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mixl_reg <= '0;
            mixr_reg <= '0;
        end
        if (cmd.run) begin
            unique case (cmd.step)
                3'd1: flo_reg  <= ram_rdata;
                3'd2: fmid_reg <= ram_rdata;
                3'd3: fhi_reg  <= ram_rdata;
                3'd4: begin
                    ctl_reg   <= ram_rdata;
                    carry_reg <= !flo_reg[0] && psum[24];
                end
                3'd5: sel_reg  <= ram_rdata[7:4];
                3'd7: begin
                    mixl_reg <= mixl_reg + 21'(addl);
                    mixr_reg <= mixr_reg + 21'(addr_r);
                end
                default: ;
            endcase
        end
        if (cmd.p0) begin
            prodl_reg <= 31'(mixl_reg * $signed({1'b0, gain_reg}));
            prodr_reg <= 31'(mixr_reg * $signed({1'b0, gain_reg}));
        end
        if (cmd.p1) begin
            accl_reg <= 41'(prodl_reg * 41'(wlas_pkg::OutScale)) + $signed({25'd0, resl_reg});
            accr_reg <= 41'(prodr_reg * 41'(wlas_pkg::OutScale)) + $signed({25'd0, resr_reg});
        end
        if (cmd.p2) begin
            clip_reg <= (ol > 25'sd32767) || (ol < -25'sd32768) ||
                        (orr > 25'sd32767) || (orr < -25'sd32768);
            if (ol > 25'sd32767) begin
                lo_reg <= 16'sd32767; resl_tmp_reg <= '0;
            end else if (ol < -25'sd32768) begin
                lo_reg <= -16'sd32768; resl_tmp_reg <= '0;
            end else begin
                lo_reg <= ol[15:0]; resl_tmp_reg <= accl_reg[15:0];
            end
            if (orr > 25'sd32767) begin
                ro_reg <= 16'sd32767; resr_tmp_reg <= '0;
            end else if (orr < -25'sd32768) begin
                ro_reg <= -16'sd32768; resr_tmp_reg <= '0;
            end else begin
                ro_reg <= orr[15:0]; resr_tmp_reg <= accr_reg[15:0];
            end
        end
        if (cmd.commit) begin
            m_tdata_reg <= {4'd0, gain_new, mixr_reg, mixl_reg, clip_all, ro_reg, lo_reg};
        end
    end

endmodule
`default_nettype wire

// File: verif/tb_wavetable_log_amp_synth_16ch.sv
`timescale 1ns / 100ps

import wlas_pkg::*;

typedef struct {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               clipped;
    logic signed [20:0] mix_left;
    logic signed [20:0] mix_right;
    logic [8:0]         gain_now;
} synth_sample_t;

class synth_scoreboard;
    logic [7:0]    ram[RamDepth];
    logic [23:0]   phase[NumChannels];
    logic [7:0]    amp[NumChannels];
    logic          bank_hi;
    logic [15:0]   res_l;
    logic [15:0]   res_r;
    int unsigned   gain;
    logic [8:0]    init_gain;
    logic          autorange;
    logic          rate48;
    logic          pin_chk;
    synth_sample_t samples_due[$];
    int            errors;

    function new();
        foreach (ram[i]) ram[i] = 8'd0;
        foreach (phase[i]) begin
            phase[i] = 24'd0;
            amp[i] = 8'd0;
        end
        bank_hi = 1'b0;
        res_l = 16'd0;
        res_r = 16'd0;
        init_gain = 9'd3;
        gain = 3;
        autorange = 1'b1;
        rate48 = 1'b0;
        pin_chk = 1'b1;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
        case (idx)
            CfgInitialGain: begin
                init_gain = val;
                gain = (val > 9'd256) ? 256 : val;
            end
            CfgAutorange: autorange = val[0];
            CfgRate48k:   rate48 = val[0];
            CfgPinSums:   pin_chk = val[0];
            default: ;
        endcase
    endfunction

    function int weight(logic [3:0] p);
        int w[16] = '{0, 0, 0, 0, 0, 0, 0, 0, 6, 6, 6, 5, 4, 3, 2, 1};
        return w[p];
    endfunction

    function int exp_lut(logic [6:0] n);
        return (1 << n[6:4]) * (2 * int'(n[3:0]) + 33) - 33;
    endfunction

    function int saturate(int v, inout logic [15:0] res, inout logic clip);
        longint acc;
        longint o;
        acc = longint'(v) * longint'(gain) * longint'(OutScale) + longint'(res);
        o = acc >>> 16;
        res = acc[15:0];
        if (o < -32768) begin
            o = -32768;
            res = 16'd0;
            clip = 1'b1;
        end
        if (o > 32767) begin
            o = 32767;
            res = 16'd0;
            clip = 1'b1;
        end
        return int'(o);
    endfunction

    function void note(logic op, logic [11:0] addr, logic [7:0] data);
        int            ml;
        int            mr;
        int            lo;
        int            ro;
        int            pan;
        int            lin;
        logic          clip;
        logic          nb;
        logic [11:0]   base;
        logic [11:0]   wa;
        logic [23:0]   freq;
        logic [31:0]   inc;
        logic [24:0]   sum;
        logic          carry;
        logic [7:0]    ctl;
        logic [3:0]    sel;
        logic [8:0]    smp;
        logic          sign;
        synth_sample_t s;
        if (op == OpWrite) begin
            ram[addr] = data;
            return;
        end
        ml = 0;
        mr = 0;
        clip = 1'b0;
        nb = bank_hi;
        for (int ch = 0; ch < NumChannels; ch++) begin
            base = 12'hE00 + (nb ? 12'd128 : 12'd0) + 12'(ch);
            freq = {ram[12'(base + 12'h20)], ram[12'(base + 12'h10)], ram[base]};
            ctl = ram[12'(base + 12'h70)];
            sel = ram[12'(base + 12'h50)][7:4];
            inc = (32'(freq) * (rate48 ? 32'd125 : 32'd128)) >> 7;
            carry = 1'b0;
            if (!ram[base][0]) begin
                sum = 25'(inc) + 25'(phase[ch]);
                phase[ch] = sum[23:0];
                carry = sum[24];
                if (carry) amp[ch] = ram[12'(base + 12'h60)];
            end else begin
                phase[ch] = inc[23:0];
            end
            wa = {sel, sel[0], phase[ch][23:17]};
            sign = ram[wa][7];
            smp = 9'(ram[wa]) + 9'(amp[ch]);
            nb = ctl[5] && (sign || carry);
            if (sign ^ smp[7]) begin
                pan = weight(ctl[3:0]);
                lin = exp_lut(smp[6:0]);
                if (ctl[4]) sign = ~sign;
                if (sign) lin = -lin;
                ml += lin * pan;
                mr += lin * (6 - pan);
            end
        end
        bank_hi = nb;
        lo = saturate(ml, res_l, clip);
        ro = saturate(mr, res_r, clip);
        if (pin_chk && (lo + ro > 32767 || lo + ro < -32768)) clip = 1'b1;
        if (clip && autorange) begin
            res_l = 16'd0;
            res_r = 16'd0;
            if (gain > 1) gain = gain / 2;
        end
        s.left_out = 16'(lo);
        s.right_out = 16'(ro);
        s.clipped = clip;
        s.mix_left = 21'(ml);
        s.mix_right = 21'(mr);
        s.gain_now = 9'(gain);
        samples_due.push_back(s);
    endfunction

    function void check(logic [87:0] d);
        synth_sample_t e;
        if (samples_due.size() == 0) begin
            $display("%0t: unexpected item %h", $time, d);
            errors++;
            return;
        end
        e = samples_due.pop_front();
        if (d[15:0] !== e.left_out) begin
            $display("%0t: left_out exp %0d got %0d", $time, e.left_out, $signed(d[15:0]));
            errors++;
        end
        if (d[31:16] !== e.right_out) begin
            $display("%0t: right_out exp %0d got %0d", $time, e.right_out, $signed(d[31:16]));
            errors++;
        end
        if (d[32] !== e.clipped) begin
            $display("%0t: clipped exp %0d got %0d", $time, e.clipped, d[32]);
            errors++;
        end
        if (d[53:33] !== e.mix_left) begin
            $display("%0t: mix_left exp %0d got %0d", $time, e.mix_left, $signed(d[53:33]));
            errors++;
        end
        if (d[74:54] !== e.mix_right) begin
            $display("%0t: mix_right exp %0d got %0d", $time, e.mix_right, $signed(d[74:54]));
            errors++;
        end
        if (d[83:75] !== e.gain_now) begin
            $display("%0t: gain_now exp %0d got %0d", $time, e.gain_now, d[83:75]);
            errors++;
        end
    endfunction
endclass

module tb_wavetable_log_amp_synth_16ch;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [8:0]  cfg_wdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    synth_scoreboard sb = new();
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned stall_cnt = 0;
    int unsigned cycles = 0;
    int          sent = 0;

    wavetable_log_amp_synth_16ch i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("wavetable_log_amp_synth_16ch verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
    end

    // hold the receiver off in bursts, or for one long stretch on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cnt != 0) begin
            m_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            stall_cnt <= 600;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_cnt <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(logic op, logic [11:0] addr, logic [7:0] data);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, data, addr, op};
        do @(posedge aclk); while (!s_tready);
        sb.note(op, addr, data);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.samples_due.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_items(int n);
        int unsigned r;
        logic [7:0]  d;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            d = $urandom_range(0, 9) == 0 ? {8{$urandom_range(0, 1) == 1}} : 8'($urandom);
            if (r < 35) send(OpTick, 12'($urandom), 8'($urandom));
            else if (r < 75) send(OpWrite, {RegPage, 8'($urandom)}, d);
            else send(OpWrite, 12'($urandom), d);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // channel 0 and 1 voices, modulate chain, phase-set mode, zero clamp
        send(OpWrite, 12'hE00, 8'h00);
        send(OpWrite, 12'hE10, 8'hFF);
        send(OpWrite, 12'hE20, 8'hFF);
        send(OpWrite, 12'hE50, 8'h10);
        send(OpWrite, 12'hE60, 8'h7F);
        send(OpWrite, 12'hE70, 8'h28);
        send(OpWrite, 12'h100, 8'hFF);
        send(OpWrite, 12'h180, 8'h85);
        send(OpWrite, 12'hE01, 8'h01);
        send(OpWrite, 12'hE11, 8'h80);
        send(OpWrite, 12'hE71, 8'h1F);
        send(OpWrite, 12'hE81, 8'hFF);
        send(OpWrite, 12'hEF1, 8'h3B);
        send(OpWrite, 12'h000, 8'h40);
        send(OpWrite, 12'hFFF, 8'hFF);
        for (int k = 0; k < 8; k++) send(OpTick, 12'hFFF, 8'hFF);
        drain();

        set_reg(CfgInitialGain, 9'd511);
        set_reg(CfgAutorange, 9'd0);
        set_reg(CfgRate48k, 9'd1);
        set_reg(CfgPinSums, 9'd0);
        hold_req = 1'b1;
        random_items(350);
        drain();

        set_reg(CfgInitialGain, 9'd0);
        set_reg(CfgAutorange, 9'd1);
        set_reg(CfgRate48k, 9'd0);
        set_reg(CfgPinSums, 9'd1);
        random_items(350);
        drain();

        set_reg(CfgInitialGain, 9'd1);
        set_reg(CfgAutorange, 9'd0);
        set_reg(CfgPinSums, 9'd1);
        random_items(350);
        drain();

        set_reg(CfgInitialGain, 9'($urandom_range(2, 256)));
        set_reg(CfgAutorange, 9'd1);
        set_reg(CfgRate48k, 9'd1);
        random_items(200);
        quiet = 1'b1;
        random_items(250);
        drain();

        if (sb.errors == 0) begin
            $display("wavetable_log_amp_synth_16ch verification clean");
        end else begin
            $display("wavetable_log_amp_synth_16ch verification failed");
        end
        $finish;
    end
endmodule
